### rtl/flvp_pkg.sv
package flvp_pkg;

	// parser phase
	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_PREV    = 3'd1,
		PH_TAG     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_HALT    = 3'd4
	} phase_t;

	// byte role codes
	localparam logic [2:0] ROLE_HEADER  = 3'd0;
	localparam logic [2:0] ROLE_PREV    = 3'd1;
	localparam logic [2:0] ROLE_TAG     = 3'd2;
	localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
	localparam logic [2:0] ROLE_IGNORED = 3'd4;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_SIGNATURE = 3'd1;
	localparam logic [2:0] ERR_VERSION   = 3'd2;
	localparam logic [2:0] ERR_RESERVED  = 3'd3;
	localparam logic [2:0] ERR_TAG_TYPE  = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED = 3'd5;

	// tag kinds
	localparam logic [1:0] KIND_AUDIO  = 2'd0;
	localparam logic [1:0] KIND_VIDEO  = 2'd1;
	localparam logic [1:0] KIND_SCRIPT = 2'd2;

	// tag type bytes
	localparam logic [7:0] TYPE_AUDIO  = 8'd8;
	localparam logic [7:0] TYPE_VIDEO  = 8'd9;
	localparam logic [7:0] TYPE_SCRIPT = 8'd18;

	// file header bytes
	localparam logic [7:0] SIG_F        = 8'h46;
	localparam logic [7:0] SIG_L        = 8'h4C;
	localparam logic [7:0] SIG_V        = 8'h56;
	localparam logic [7:0] VERSION_1    = 8'h01;
	localparam logic [7:0] FLAG_RSV_HI  = 8'hF8;
	localparam logic [7:0] FLAG_RSV_LO  = 8'h02;

	// byte positions within each section
	localparam logic [23:0] IDX_SIG_F     = 24'd0;
	localparam logic [23:0] IDX_SIG_L     = 24'd1;
	localparam logic [23:0] IDX_SIG_V     = 24'd2;
	localparam logic [23:0] IDX_VERSION   = 24'd3;
	localparam logic [23:0] IDX_FLAGS     = 24'd4;
	localparam logic [23:0] IDX_HDR_LAST  = 24'd8;
	localparam logic [23:0] IDX_PREV_LAST = 24'd3;
	localparam logic [23:0] IDX_TAG_TYPE  = 24'd0;
	localparam logic [23:0] IDX_SIZE_LAST = 24'd3;
	localparam logic [23:0] IDX_TIME_LAST = 24'd6;
	localparam logic [23:0] IDX_SID_FIRST = 24'd8;
	localparam logic [23:0] IDX_TAG_LAST  = 24'd10;

endpackage

### rtl/flvp_in_if.sv
interface flvp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

### rtl/flvp_out_if.sv
interface flvp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  byte_role;
	logic [7:0]  payload_byte;
	logic        payload_last;
	logic        tag_ready;
	logic [1:0]  tag_kind;
	logic [23:0] payload_size;
	logic [23:0] time_low;
	logic [23:0] stream_number;
	logic        prev_size_ready;
	logic [31:0] prev_tag_size;
	logic [1:0]  stream_flags;
	logic [2:0]  error_code;

	modport source (
		output valid, input ready,
		output byte_role, output payload_byte, output payload_last, output tag_ready,
		output tag_kind, output payload_size, output time_low, output stream_number,
		output prev_size_ready, output prev_tag_size, output stream_flags, output error_code
	);
	modport sink (
		input valid, output ready,
		input byte_role, input payload_byte, input payload_last, input tag_ready,
		input tag_kind, input payload_size, input time_low, input stream_number,
		input prev_size_ready, input prev_tag_size, input stream_flags, input error_code
	);
endinterface

### rtl/flv_tag_header_parser.sv
// flv tag header parser: one stream byte in, one result out per transfer
// latency: a result is valid the cycle after its byte transfer
// throughput: one byte per cycle; the result register frees up in the same
// cycle the downstream takes it, so input stalls only while the output stalls
// reset: arst_n clears phase, counters, fields, flags, error and output valid
module flv_tag_header_parser (
	input  logic              clk,
	input  logic              arst_n,
	flvp_in_if.sink           stream,
	flvp_out_if.source        result
);

	flvp_pkg::phase_t phase_q, phase_d;
	logic [23:0] idx_q, idx_d;
	logic [31:0] prev_q, prev_d;
	logic [1:0]  kind_q, kind_d;
	logic [23:0] size_q, size_d;
	logic [23:0] time_q, time_d;
	logic [23:0] sid_q, sid_d;
	logic [1:0]  flags_q, flags_d;
	logic [2:0]  err_q, err_d;

	logic [2:0]  role;
	logic [7:0]  pay;
	logic        plast;
	logic        tready;
	logic        pready;
	logic [2:0]  new_err;
	logic        clean_end;
	logic        active;
	logic [24:0] idx_inc;
	logic [7:0]  b;

	logic        res_valid_q;
	logic [2:0]  role_q;
	logic [7:0]  pay_q;
	logic        plast_q;
	logic        tready_q;
	logic        pready_q;
	logic [1:0]  out_kind_q;
	logic [23:0] out_size_q;
	logic [23:0] out_time_q;
	logic [23:0] out_sid_q;
	logic [31:0] out_prev_q;
	logic [1:0]  out_flags_q;
	logic [2:0]  out_err_q;

	logic in_xfer;

	// result register frees when empty or being drained
	assign stream.ready = !res_valid_q || result.ready;
	assign in_xfer      = stream.valid && stream.ready;
	assign b            = stream.data_byte;
	assign idx_inc      = {1'b0, idx_q} + 25'd1;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= flvp_pkg::PH_HEADER;
			idx_q   <= '0;
			prev_q  <= '0;
			kind_q  <= flvp_pkg::KIND_AUDIO;
			size_q  <= '0;
			time_q  <= '0;
			sid_q   <= '0;
			flags_q <= '0;
			err_q   <= flvp_pkg::ERR_NONE;
		end else if (in_xfer) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			prev_q  <= prev_d;
			kind_q  <= kind_d;
			size_q  <= size_d;
			time_q  <= time_d;
			sid_q   <= sid_d;
			flags_q <= flags_d;
			err_q   <= err_d;
		end
	end

	// next state and per-byte result
	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		prev_d    = prev_q;
		kind_d    = kind_q;
		size_d    = size_q;
		time_d    = time_q;
		sid_d     = sid_q;
		flags_d   = flags_q;
		err_d     = err_q;
		role      = flvp_pkg::ROLE_IGNORED;
		pay       = '0;
		plast     = 1'b0;
		tready    = 1'b0;
		pready    = 1'b0;
		new_err   = flvp_pkg::ERR_NONE;
		clean_end = 1'b0;
		active    = 1'b1;

		case (phase_q)
			flvp_pkg::PH_HEADER: begin
				role = flvp_pkg::ROLE_HEADER;
				if (idx_q == flvp_pkg::IDX_SIG_F && b != flvp_pkg::SIG_F) begin
					new_err = flvp_pkg::ERR_SIGNATURE;
				end else if (idx_q == flvp_pkg::IDX_SIG_L && b != flvp_pkg::SIG_L) begin
					new_err = flvp_pkg::ERR_SIGNATURE;
				end else if (idx_q == flvp_pkg::IDX_SIG_V && b != flvp_pkg::SIG_V) begin
					new_err = flvp_pkg::ERR_SIGNATURE;
				end else if (idx_q == flvp_pkg::IDX_VERSION && b != flvp_pkg::VERSION_1) begin
					new_err = flvp_pkg::ERR_VERSION;
				end else if (idx_q == flvp_pkg::IDX_FLAGS) begin
					// bit1 audio, bit0 video
					flags_d = {b[2], b[0]};
					if ((b & flvp_pkg::FLAG_RSV_HI) != 8'd0 ||
					    (b & flvp_pkg::FLAG_RSV_LO) != 8'd0) begin
						new_err = flvp_pkg::ERR_RESERVED;
					end
				end
				if (idx_q >= flvp_pkg::IDX_HDR_LAST) begin
					phase_d = flvp_pkg::PH_PREV;
					idx_d   = '0;
				end else begin
					idx_d = idx_inc[23:0];
				end
			end
			flvp_pkg::PH_PREV: begin
				role   = flvp_pkg::ROLE_PREV;
				prev_d = {prev_q[23:0], b};
				if (idx_q >= flvp_pkg::IDX_PREV_LAST) begin
					pready    = 1'b1;
					idx_d     = '0;
					phase_d   = flvp_pkg::PH_TAG;
					clean_end = stream.end_of_stream;
				end else begin
					idx_d = idx_inc[23:0];
				end
			end
			flvp_pkg::PH_TAG: begin
				role = flvp_pkg::ROLE_TAG;
				if (idx_q == flvp_pkg::IDX_TAG_TYPE) begin
					if (b == flvp_pkg::TYPE_AUDIO) begin
						kind_d = flvp_pkg::KIND_AUDIO;
					end else if (b == flvp_pkg::TYPE_VIDEO) begin
						kind_d = flvp_pkg::KIND_VIDEO;
					end else if (b == flvp_pkg::TYPE_SCRIPT) begin
						kind_d = flvp_pkg::KIND_SCRIPT;
					end else begin
						new_err = flvp_pkg::ERR_TAG_TYPE;
					end
				end else if (idx_q <= flvp_pkg::IDX_SIZE_LAST) begin
					size_d = {size_q[15:0], b};
				end else if (idx_q <= flvp_pkg::IDX_TIME_LAST) begin
					time_d = {time_q[15:0], b};
				end else if (idx_q >= flvp_pkg::IDX_SID_FIRST) begin
					sid_d = {sid_q[15:0], b};
				end
				if (idx_q >= flvp_pkg::IDX_TAG_LAST) begin
					tready  = 1'b1;
					idx_d   = '0;
					// empty tag skips straight to the next size field
					phase_d = (size_d != 24'd0) ? flvp_pkg::PH_PAYLOAD : flvp_pkg::PH_PREV;
				end else begin
					idx_d = idx_inc[23:0];
				end
			end
			flvp_pkg::PH_PAYLOAD: begin
				role = flvp_pkg::ROLE_PAYLOAD;
				pay  = b;
				if (size_q == 24'd0 || idx_inc >= {1'b0, size_q}) begin
					plast   = 1'b1;
					idx_d   = '0;
					phase_d = flvp_pkg::PH_PREV;
				end else begin
					idx_d = idx_inc[23:0];
				end
			end
			default: begin
				active = 1'b0;
			end
		endcase

		// format error beats clean end, clean end beats truncation
		if (active) begin
			if (new_err != flvp_pkg::ERR_NONE) begin
				err_d   = new_err;
				phase_d = flvp_pkg::PH_HALT;
			end else if (clean_end) begin
				phase_d = flvp_pkg::PH_HALT;
			end else if (stream.end_of_stream) begin
				err_d   = flvp_pkg::ERR_TRUNCATED;
				phase_d = flvp_pkg::PH_HALT;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_xfer) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			role_q      <= role;
			pay_q       <= pay;
			plast_q     <= plast;
			tready_q    <= tready;
			pready_q    <= pready;
			out_kind_q  <= kind_d;
			out_size_q  <= size_d;
			out_time_q  <= time_d;
			out_sid_q   <= sid_d;
			out_prev_q  <= prev_d;
			out_flags_q <= flags_d;
			out_err_q   <= err_d;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.byte_role       = role_q;
	assign result.payload_byte    = pay_q;
	assign result.payload_last    = plast_q;
	assign result.tag_ready       = tready_q;
	assign result.tag_kind        = out_kind_q;
	assign result.payload_size    = out_size_q;
	assign result.time_low        = out_time_q;
	assign result.stream_number   = out_sid_q;
	assign result.prev_size_ready = pready_q;
	assign result.prev_tag_size   = out_prev_q;
	assign result.stream_flags    = out_flags_q;
	assign result.error_code      = out_err_q;

endmodule

### rtl/flvp_checker.sv
module flvp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] byte_role,
	input logic [7:0] payload_byte,
	input logic       payload_last,
	input logic       tag_ready,
	input logic       prev_size_ready,
	input logic [2:0] error_code
);

	logic       out_xfer;
	logic       seen_err_q;
	logic [2:0] last_err_q;

	assign out_xfer = res_valid && res_ready;

	// remember the first error shown on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_err_q <= 1'b0;
			last_err_q <= flvp_pkg::ERR_NONE;
		end else if (out_xfer && error_code != flvp_pkg::ERR_NONE && !seen_err_q) begin
			seen_err_q <= 1'b1;
			last_err_q <= error_code;
		end
	end

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// errors are sticky
	a_sticky_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && seen_err_q |-> error_code == last_err_q)
		else $error("error code changed after an error");

	// at most one section end per byte
	a_one_marker: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot0({payload_last, tag_ready, prev_size_ready}))
		else $error("several section markers on one byte");

	// markers match the byte role
	a_marker_role: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!payload_last || byte_role == flvp_pkg::ROLE_PAYLOAD) &&
		              (!tag_ready || byte_role == flvp_pkg::ROLE_TAG) &&
		              (!prev_size_ready || byte_role == flvp_pkg::ROLE_PREV))
		else $error("section marker on a byte of the wrong role");

	// only payload bytes pass data through
	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && byte_role != flvp_pkg::ROLE_PAYLOAD |-> payload_byte == 8'd0)
		else $error("payload byte set outside payload");

endmodule

bind flv_tag_header_parser flvp_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.byte_role       (result.byte_role),
	.payload_byte    (result.payload_byte),
	.payload_last    (result.payload_last),
	.tag_ready       (result.tag_ready),
	.prev_size_ready (result.prev_size_ready),
	.error_code      (result.error_code)
);
